### design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Types, microcode encoding and control store of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;
  localparam int STEP_W = 5;

  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_SET   = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t            mode;
    logic [7:0]       glyph;
    logic [3:0]       fg_color;
    logic [3:0]       bg_color;
    logic [COL_W-1:0] pos_x;
    logic [ROW_W-1:0] pos_y;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic [CELL_W-1:0] cell_value;
    logic              did_scroll;
    logic              accepted;
  } result_t;

  typedef enum logic [1:0] {
    ADDR_PTR      = 2'd0,
    ADDR_PTR_COLS = 2'd1,
    ADDR_CURSOR   = 2'd2,
    ADDR_POS      = 2'd3
  } addr_sel_t;

  typedef enum logic [1:0] {
    DATA_ZERO  = 2'd0,
    DATA_BLANK = 2'd1,
    DATA_CHAR  = 2'd2,
    DATA_RDATA = 2'd3
  } data_sel_t;

  typedef enum logic [1:0] {
    PTR_HOLD = 2'd0,
    PTR_CLR  = 2'd1,
    PTR_INC  = 2'd2
  } ptr_op_t;

  typedef enum logic [2:0] {
    CUR_HOLD     = 3'd0,
    CUR_WRAP     = 3'd1,
    CUR_LAST_ROW = 3'd2,
    CUR_INC_COL  = 3'd3,
    CUR_LOAD_POS = 3'd4
  } cur_op_t;

  typedef enum logic [2:0] {
    COND_NONE              = 3'd0,
    COND_NOT_COL_FULL      = 3'd1,
    COND_NOT_ROW_OVER      = 3'd2,
    COND_NOT_PTR_COPY_LAST = 3'd3,
    COND_NOT_PTR_LAST      = 3'd4
  } cond_t;

  typedef struct packed {
    logic              mem_we;
    logic              mem_re;
    addr_sel_t         addr_sel;
    data_sel_t         wdata_sel;
    data_sel_t         res_sel;
    ptr_op_t           ptr_op;
    cur_op_t           cur_op;
    logic              set_scroll;
    cond_t             cond;
    logic [STEP_W-1:0] target;
    logic              finish;
    logic              emit;
  } ctrl_t;

  typedef struct packed {
    logic col_full;
    logic row_over;
    logic ptr_copy_last;
    logic ptr_last;
  } status_t;

  localparam logic [STEP_W-1:0] S_INIT       = 5'd0;
  localparam logic [STEP_W-1:0] S_INIT_FILL  = 5'd1;
  localparam logic [STEP_W-1:0] S_INIT_END   = 5'd2;
  localparam logic [STEP_W-1:0] S_PUT        = 5'd3;
  localparam logic [STEP_W-1:0] S_PUT_WRAP   = 5'd4;
  localparam logic [STEP_W-1:0] S_PUT_SCROLL = 5'd5;
  localparam logic [STEP_W-1:0] S_COPY_RD    = 5'd6;
  localparam logic [STEP_W-1:0] S_COPY_WR    = 5'd7;
  localparam logic [STEP_W-1:0] S_BLANK      = 5'd8;
  localparam logic [STEP_W-1:0] S_LAST_ROW   = 5'd9;
  localparam logic [STEP_W-1:0] S_PUT_WR     = 5'd10;
  localparam logic [STEP_W-1:0] S_SET        = 5'd11;
  localparam logic [STEP_W-1:0] S_CLR        = 5'd12;
  localparam logic [STEP_W-1:0] S_CLR_FILL   = 5'd13;
  localparam logic [STEP_W-1:0] S_CLR_END    = 5'd14;
  localparam logic [STEP_W-1:0] S_RD         = 5'd15;
  localparam logic [STEP_W-1:0] S_RD_END     = 5'd16;

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = '0;
    case (step)
      S_INIT: begin
        c.ptr_op = PTR_CLR;
      end
      S_INIT_FILL: begin
        c.mem_we    = 1'b1;
        c.addr_sel  = ADDR_PTR;
        c.wdata_sel = DATA_ZERO;
        c.ptr_op    = PTR_INC;
        c.cond      = COND_NOT_PTR_LAST;
        c.target    = S_INIT_FILL;
      end
      S_INIT_END: begin
        c.finish = 1'b1;
      end
      S_PUT: begin
        c.cond   = COND_NOT_COL_FULL;
        c.target = S_PUT_SCROLL;
      end
      S_PUT_WRAP: begin
        c.cur_op = CUR_WRAP;
      end
      S_PUT_SCROLL: begin
        c.ptr_op = PTR_CLR;
        c.cond   = COND_NOT_ROW_OVER;
        c.target = S_PUT_WR;
      end
      S_COPY_RD: begin
        c.mem_re   = 1'b1;
        c.addr_sel = ADDR_PTR_COLS;
      end
      S_COPY_WR: begin
        c.mem_we    = 1'b1;
        c.addr_sel  = ADDR_PTR;
        c.wdata_sel = DATA_RDATA;
        c.ptr_op    = PTR_INC;
        c.cond      = COND_NOT_PTR_COPY_LAST;
        c.target    = S_COPY_RD;
      end
      S_BLANK: begin
        c.mem_we     = 1'b1;
        c.addr_sel   = ADDR_PTR;
        c.wdata_sel  = DATA_BLANK;
        c.ptr_op     = PTR_INC;
        c.set_scroll = 1'b1;
        c.cond       = COND_NOT_PTR_LAST;
        c.target     = S_BLANK;
      end
      S_LAST_ROW: begin
        c.cur_op = CUR_LAST_ROW;
      end
      S_PUT_WR: begin
        c.mem_we    = 1'b1;
        c.addr_sel  = ADDR_CURSOR;
        c.wdata_sel = DATA_CHAR;
        c.res_sel   = DATA_CHAR;
        c.cur_op    = CUR_INC_COL;
        c.finish    = 1'b1;
        c.emit      = 1'b1;
      end
      S_SET: begin
        c.cur_op  = CUR_LOAD_POS;
        c.res_sel = DATA_ZERO;
        c.finish  = 1'b1;
        c.emit    = 1'b1;
      end
      S_CLR: begin
        c.ptr_op = PTR_CLR;
      end
      S_CLR_FILL: begin
        c.mem_we    = 1'b1;
        c.addr_sel  = ADDR_PTR;
        c.wdata_sel = DATA_BLANK;
        c.ptr_op    = PTR_INC;
        c.cond      = COND_NOT_PTR_LAST;
        c.target    = S_CLR_FILL;
      end
      S_CLR_END: begin
        c.res_sel = DATA_BLANK;
        c.finish  = 1'b1;
        c.emit    = 1'b1;
      end
      S_RD: begin
        c.mem_re   = 1'b1;
        c.addr_sel = ADDR_POS;
      end
      S_RD_END: begin
        c.res_sel = DATA_RDATA;
        c.finish  = 1'b1;
        c.emit    = 1'b1;
      end
      default: begin
        c.finish = 1'b1;
      end
    endcase
    return c;
  endfunction

endpackage

### design/tcw_sequencer.sv
// ----------------------------------------------------------------------------
// tcw_sequencer
// Step counter over the control store, with dispatch on mode and jumps.
// ----------------------------------------------------------------------------
module tcw_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  tcw_pkg::mode_t  mode,
  input  tcw_pkg::status_t status,
  output tcw_pkg::ctrl_t  ctrl,
  output logic            busy
);
  import tcw_pkg::*;

  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;
  logic              running;
  logic              running_next;
  logic [STEP_W-1:0] entry;
  logic              jump;
  ctrl_t             word;

  assign word = ucode(pc);
  assign ctrl = running ? word : '0;
  assign busy = running;

  always_comb begin
    case (mode)
      MODE_PUT:   entry = S_PUT;
      MODE_SET:   entry = S_SET;
      MODE_CLEAR: entry = S_CLR;
      MODE_READ:  entry = S_RD;
      default:    entry = S_SET;
    endcase
  end

  always_comb begin
    case (word.cond)
      COND_NONE:              jump = 1'b0;
      COND_NOT_COL_FULL:      jump = !status.col_full;
      COND_NOT_ROW_OVER:      jump = !status.row_over;
      COND_NOT_PTR_COPY_LAST: jump = !status.ptr_copy_last;
      COND_NOT_PTR_LAST:      jump = !status.ptr_last;
      default:                jump = 1'b0;
    endcase
  end

  always_comb begin
    pc_next      = pc;
    running_next = running;
    if (accept) begin
      pc_next      = entry;
      running_next = 1'b1;
    end else if (running) begin
      if (jump) begin
        pc_next = word.target;
      end else if (word.finish) begin
        running_next = 1'b0;
      end else begin
        pc_next = pc + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc      <= S_INIT;
      running <= 1'b1;
    end else begin
      pc      <= pc_next;
      running <= running_next;
    end
  end

endmodule

### design/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath
// Cell store, cursor, sweep pointer and result register.
// ----------------------------------------------------------------------------
module tcw_datapath #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  tcw_pkg::in_item_t item,
  input  tcw_pkg::ctrl_t    ctrl,
  output tcw_pkg::status_t  status,
  output logic              done,
  output tcw_pkg::result_t  result
);
  import tcw_pkg::*;

  localparam int CELLS  = COLS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  in_item_t          item_q;
  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata;
  logic [ADDR_W-1:0] ptr;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] cur_idx;
  logic [ADDR_W-1:0] pos_idx;
  logic [CELL_W-1:0] wdata;
  logic [CELL_W-1:0] blank;
  logic [CELL_W-1:0] char_cell;
  logic [CELL_W-1:0] res_cell;
  logic [COL_W-1:0]  col;
  logic [COL_W-1:0]  col_next;
  logic [ROW_W-1:0]  row;
  logic [ROW_W-1:0]  row_next;
  logic              scroll;
  logic              on_screen;
  logic              pos_mode;

  assign blank     = {item_q.bg_color, item_q.fg_color, 8'h00};
  assign char_cell = {item_q.bg_color, item_q.fg_color, item_q.glyph};
  assign on_screen = (item_q.pos_x < COL_W'(COLS)) && (item_q.pos_y < ROW_W'(ROWS));
  assign pos_mode  = (item_q.mode == MODE_SET) || (item_q.mode == MODE_READ);

  assign cur_idx = ADDR_W'(int'(row) * COLS + int'(col));
  assign pos_idx = on_screen ? ADDR_W'(int'(item_q.pos_y) * COLS + int'(item_q.pos_x))
                             : '0;

  assign status.col_full      = col >= COL_W'(COLS);
  assign status.row_over      = row >= ROW_W'(ROWS);
  assign status.ptr_copy_last = ptr == ADDR_W'(CELLS - COLS - 1);
  assign status.ptr_last      = ptr == ADDR_W'(CELLS - 1);

  always_comb begin
    case (ctrl.addr_sel)
      ADDR_PTR:      addr = ptr;
      ADDR_PTR_COLS: addr = ADDR_W'(int'(ptr) + COLS);
      ADDR_CURSOR:   addr = cur_idx;
      ADDR_POS:      addr = pos_idx;
      default:       addr = ptr;
    endcase
  end

  always_comb begin
    case (ctrl.wdata_sel)
      DATA_ZERO:  wdata = '0;
      DATA_BLANK: wdata = blank;
      DATA_CHAR:  wdata = char_cell;
      DATA_RDATA: wdata = rdata;
      default:    wdata = '0;
    endcase
  end

  always_comb begin
    case (ctrl.res_sel)
      DATA_ZERO:  res_cell = '0;
      DATA_BLANK: res_cell = blank;
      DATA_CHAR:  res_cell = char_cell;
      DATA_RDATA: res_cell = on_screen ? rdata : '0;
      default:    res_cell = '0;
    endcase
  end

  always_comb begin
    col_next = col;
    row_next = row;
    case (ctrl.cur_op)
      CUR_HOLD: begin
      end
      CUR_WRAP: begin
        col_next = '0;
        row_next = row + 1'b1;
      end
      CUR_LAST_ROW: begin
        row_next = ROW_W'(ROWS - 1);
      end
      CUR_INC_COL: begin
        col_next = col + 1'b1;
      end
      CUR_LOAD_POS: begin
        if (on_screen) begin
          col_next = item_q.pos_x;
          row_next = item_q.pos_y;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mem_we) begin
      mem[addr] <= wdata;
    end
    if (ctrl.mem_re) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
    end
    case (ctrl.ptr_op)
      PTR_CLR: ptr <= '0;
      PTR_INC: ptr <= ptr + 1'b1;
      default: ptr <= ptr;
    endcase
    if (ctrl.emit) begin
      result.cur_col    <= col_next;
      result.cur_row    <= row_next;
      result.cell_value <= res_cell;
      result.did_scroll <= scroll;
      result.accepted   <= pos_mode ? on_screen : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col    <= '0;
      row    <= '0;
      scroll <= 1'b0;
      done   <= 1'b0;
    end else begin
      col  <= col_next;
      row  <= row_next;
      done <= ctrl.emit;
      if (accept) begin
        scroll <= 1'b0;
      end else if (ctrl.set_scroll) begin
        scroll <= 1'b1;
      end
    end
  end

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    ctrl.mem_we && (ctrl.addr_sel == ADDR_CURSOR) |-> row < ROW_W'(ROWS) && col < COL_W'(COLS))
    else $error("cell write outside the screen");

  a_scroll_only_put: assert property (@(posedge clk) disable iff (rst)
    done && result.did_scroll |-> $past(item_q.mode) == MODE_PUT)
    else $error("scroll flagged on a non-put item");

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    col <= COL_W'(COLS))
    else $error("cursor column beyond width");

endmodule

### design/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode character console: cursor plus a store of colour cells.
// ----------------------------------------------------------------------------
// After reset the block is busy while a clearing pass zeroes the cell store
// one cell per cycle. An item is taken when start is high and busy is low;
// its result appears on result for the single cycle in which done is high,
// and busy drops in that same cycle, so the next item may be started there.
// The receiver cannot stall. A put character passes through a wrap step when
// the column is full, and through the scroll steps when the cursor has moved
// past the last row. A put with scroll and a clear are the longest items,
// set by the single-port cell store, which a scroll walks with one read step
// and one write step per copied cell and then one write per cell of the last
// row, and which a clear walks with one write per cell.
module text_console_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tcw_pkg::in_item_t item,
  output logic              done,
  output tcw_pkg::result_t  result
);
  import tcw_pkg::*;

  ctrl_t   ctrl;
  status_t status;
  logic    accept;

  assign accept = start && !busy;

  tcw_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .mode   (item.mode),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  tcw_datapath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .ctrl   (ctrl),
    .status (status),
    .done   (done),
    .result (result)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("item taken but sequencer not running");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> busy)
    else $error("no clearing pass after reset");

  a_result_row: assert property (@(posedge clk) disable iff (rst)
    done |-> result.cur_row < ROW_W'(ROWS))
    else $error("cursor row beyond last row");

endmodule
